>>> rtl/core/fdcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdcd_pkg
// Shared constants and helpers of the frame difference-hash change detector.
// ----------------------------------------------------------------------------
package fdcd_pkg;

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int GRID       = 9;
    localparam int CELLS      = GRID * GRID;
    localparam int HASH_W     = 64;
    localparam int CFG_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int COUNT_W    = 7;
    localparam int QDEPTH     = 8;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int DIVW       = 19;
    localparam int IN_TDATA_W = 24;
    localparam int OUT_TDATA_W = 80;

    localparam int CHG_LSB  = 64;
    localparam int CMP_BIT  = 71;
    localparam int PASS_BIT = 72;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN    = 2'd3;

    localparam logic [CFG_W-1:0]   RST_WIDTH  = 13'd640;
    localparam logic [CFG_W-1:0]   RST_HEIGHT = 13'd480;
    localparam logic [COUNT_W-1:0] RST_MIN    = 7'd4;

    // Floor of v / 9 by a reciprocal multiply and one correction step.
    function automatic logic [DIVW-1:0] div9(input logic [DIVW-1:0] v);
        logic [DIVW+16:0] p;
        logic [DIVW-1:0]  q;
        logic [DIVW+3:0]  r;
        p = {17'd0, v} * {{DIVW{1'b0}}, 17'd116508};
        q = p[DIVW+16:20] == '0 ? '0 : DIVW'(p[DIVW+16:20]);
        r = {4'd0, v} - (DIVW+4)'(q) * (DIVW+4)'(GRID);
        if (r >= (DIVW+4)'(GRID))
        begin
            q = q + DIVW'(1);
        end
        return q;
    endfunction

endpackage

>>> rtl/core/fdcd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdcd_front
// Pixel intake: position counters, grid sampling, gray conversion and hash.
// ----------------------------------------------------------------------------
module fdcd_front
    import fdcd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CFG_W-1:0]      cfg_width,
    input  logic [CFG_W-1:0]      cfg_height,
    input  logic                  settling,
    input  logic [QCNT_W-1:0]     queue_count,
    input  logic                  pix_valid,
    output logic                  pix_ready,
    input  logic [7:0]            red,
    input  logic [7:0]            green,
    input  logic [7:0]            blue,
    output logic                  push,
    output logic [HASH_W-1:0]     push_hash
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [WW-1:0]    w_eff_reg;
    logic [HW-1:0]    h_eff_reg;
    logic [CW-1:0]    cbound_reg [GRID];
    logic [RW-1:0]    rbound_reg [GRID];
    logic [CW-1:0]    col_reg;
    logic [RW-1:0]    row_reg;
    logic             a_valid_reg;
    logic             a_end_reg;
    logic [CELLS-1:0] a_en_reg;
    logic [7:0]       a_gray_reg;
    logic             b_end_reg;
    logic             h_valid_reg;
    logic [HASH_W-1:0] h_hash_reg;
    logic [7:0]       cell_reg [CELLS];

    logic             accept;
    logic             row_done;
    logic             frame_done;
    logic [GRID-1:0]  col_hit;
    logic [GRID-1:0]  row_hit;
    logic [CELLS-1:0] en_next;
    logic [23:0]      gray_sum;
    logic [HASH_W-1:0] hash_next;
    logic [QCNT_W+1:0] used;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_eff_reg <= WW'(1);
            h_eff_reg <= HW'(1);
        end
        else
        begin
            if (cfg_width == '0)
                w_eff_reg <= WW'(1);
            else if ({4'd0, cfg_width} > 17'(MAX_WIDTH))
                w_eff_reg <= WW'(MAX_WIDTH);
            else
                w_eff_reg <= WW'(cfg_width);
            if (cfg_height == '0)
                h_eff_reg <= HW'(1);
            else if ({4'd0, cfg_height} > 17'(MAX_HEIGHT))
                h_eff_reg <= HW'(MAX_HEIGHT);
            else
                h_eff_reg <= HW'(cfg_height);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < GRID; i++)
        begin
            cbound_reg[i] <= CW'(div9(DIVW'(i) * DIVW'(w_eff_reg)));
            rbound_reg[i] <= RW'(div9(DIVW'(i) * DIVW'(h_eff_reg)));
        end
    end

    assign used = (QCNT_W+2)'(queue_count) + (QCNT_W+2)'(a_valid_reg & a_end_reg)
                + (QCNT_W+2)'(b_end_reg) + (QCNT_W+2)'(h_valid_reg);
    assign pix_ready = !settling && (used < (QCNT_W+2)'(QDEPTH));
    assign accept    = pix_valid && pix_ready;

    assign row_done   = ({{(WW-CW){1'b0}}, col_reg} + WW'(1)) >= w_eff_reg;
    assign frame_done = row_done && (({{(HW-RW){1'b0}}, row_reg} + HW'(1)) >= h_eff_reg);

    always_comb
    begin
        for (int i = 0; i < GRID; i++)
        begin
            col_hit[i] = (cbound_reg[i] == col_reg);
            row_hit[i] = (rbound_reg[i] == row_reg);
        end
        for (int y = 0; y < GRID; y++)
        begin
            for (int x = 0; x < GRID; x++)
            begin
                en_next[y*GRID+x] = row_hit[y] && col_hit[x];
            end
        end
    end

    assign gray_sum = 24'd19595 * {16'd0, red} + 24'd38470 * {16'd0, green}
                    + 24'd7471 * {16'd0, blue};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
            a_end_reg   <= 1'b0;
            b_end_reg   <= 1'b0;
            h_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= accept;
            b_end_reg   <= a_valid_reg && a_end_reg;
            h_valid_reg <= b_end_reg;
            if (accept)
            begin
                a_end_reg <= frame_done;
                if (row_done)
                begin
                    col_reg <= '0;
                    row_reg <= frame_done ? '0 : row_reg + RW'(1);
                end
                else
                begin
                    col_reg <= col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_en_reg   <= en_next;
            a_gray_reg <= gray_sum[23:16];
        end
        for (int i = 0; i < CELLS; i++)
        begin
            if (a_valid_reg && a_en_reg[i])
                cell_reg[i] <= a_gray_reg;
        end
        h_hash_reg <= hash_next;
    end

    always_comb
    begin
        for (int y = 0; y < GRID - 1; y++)
        begin
            for (int x = 0; x < GRID - 1; x++)
            begin
                hash_next[y*(GRID-1)+x] = cell_reg[y*GRID+x] > cell_reg[y*GRID+x+1];
            end
        end
    end

    assign push      = h_valid_reg;
    assign push_hash = h_hash_reg;

endmodule

>>> rtl/core/fdcd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdcd_queue
// Short queue of finished frame hashes between intake and comparison.
// ----------------------------------------------------------------------------
module fdcd_queue
    import fdcd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  logic [HASH_W-1:0]  push_hash,
    input  logic               pop,
    output logic               not_empty,
    output logic [HASH_W-1:0]  head_hash,
    output logic [QCNT_W-1:0]  count
);

    logic [HASH_W-1:0] slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_reg;
    logic [QPTR_W-1:0] rd_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + QPTR_W'(1);
            if (pop)
                rd_reg <= rd_reg + QPTR_W'(1);
            count_reg <= count_reg + QCNT_W'(push) - QCNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_reg] <= push_hash;
    end

    assign not_empty = (count_reg != '0);
    assign head_hash = slot_reg[rd_reg];
    assign count     = count_reg;

endmodule

>>> rtl/core/fdcd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdcd_back
// Compares each hash, while detection is enabled, with the last hash stored and presents the result beat.
// ----------------------------------------------------------------------------
module fdcd_back
    import fdcd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    detect_enable,
    input  logic [COUNT_W-1:0]      min_changed_bits,
    input  logic                    q_not_empty,
    input  logic [HASH_W-1:0]       q_hash,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_TDATA_W-1:0]  m_tdata
);

    logic [HASH_W-1:0] prev_reg;
    logic              s1_valid_reg;
    logic [HASH_W-1:0] s1_hash_reg;
    logic [3:0]        s1_part_reg [8];
    logic              s1_cmp_reg;
    logic              out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic              s1_adv;
    logic [HASH_W-1:0] diff;
    logic [3:0]        part [8];
    logic [COUNT_W-1:0] total;
    logic [COUNT_W-1:0] chg;

    assign s1_adv = s1_valid_reg && (!out_valid_reg || m_tready);
    assign pop    = q_not_empty && (!s1_valid_reg || s1_adv);
    assign diff   = q_hash ^ prev_reg;

    always_comb
    begin
        for (int k = 0; k < 8; k++)
        begin
            part[k] = '0;
            for (int j = 0; j < 8; j++)
            begin
                part[k] = part[k] + 4'(diff[k*8+j]);
            end
        end
        total = '0;
        for (int k = 0; k < 8; k++)
        begin
            total = total + COUNT_W'(s1_part_reg[k]);
        end
        chg = s1_cmp_reg ? total : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                s1_valid_reg <= 1'b1;
            else if (s1_adv)
                s1_valid_reg <= 1'b0;
            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (pop && detect_enable)
                prev_reg <= q_hash;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_hash_reg <= q_hash;
            s1_part_reg <= part;
            s1_cmp_reg  <= detect_enable && (prev_reg != '0);
        end
        if (s1_adv)
        begin
            out_data_reg <= {7'd0,
                             !s1_cmp_reg || (chg >= min_changed_bits),
                             s1_cmp_reg, chg, s1_hash_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

>>> rtl/core/frame_dhash_change_detector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_dhash_change_detector_unit
// Per-frame 64-bit difference hash with change detection against the last.
// ----------------------------------------------------------------------------
// Pixels enter on the s_ channel in raster order, one per beat, with red in
// s_tdata[7:0], green in [15:8] and blue in [23:16]. The frame size comes
// from the cfg_ channel, which always accepts a write. After every write the
// pixel channel holds s_tready low while the grid positions
// are recomputed by the divide-by-nine units.
// One pixel is taken per cycle while s_tready is high. The last pixel of a
// frame raises m_tvalid once its end flag has passed the a_, b_ and h_
// registers and its hash an eight-entry queue and the compare and output
// registers, so the pixel side keeps running while the receiver stalls until
// the queued and in-flight hashes reach eight, and only then deasserts s_tready.
// Reset restores the default configuration, clears the position counters
// and the stored previous hash, and holds s_tready low after release until
// the settle counter has run down; the grid samples are not cleared.
// ----------------------------------------------------------------------------
module frame_dhash_change_detector_unit
    import fdcd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // red, green, blue
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // frame_hash, changed_bits, compared, process_frame
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    logic               enable_reg;
    logic [COUNT_W-1:0] min_reg;
    logic [1:0]         settle_reg;

    logic               push;
    logic [HASH_W-1:0]  push_hash;
    logic               pop;
    logic               q_not_empty;
    logic [HASH_W-1:0]  q_hash;
    logic [QCNT_W-1:0]  q_count;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RST_WIDTH;
            height_reg <= RST_HEIGHT;
            enable_reg <= 1'b1;
            min_reg    <= RST_MIN;
            settle_reg <= 2'd2;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                settle_reg <= 2'd2;
                case (cfg_index)
                    REG_WIDTH:  width_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    REG_ENABLE: enable_reg <= cfg_data[0];
                    REG_MIN:    min_reg    <= cfg_data[COUNT_W-1:0];
                    default:    ;
                endcase
            end
            else if (settle_reg != '0)
            begin
                settle_reg <= settle_reg - 2'd1;
            end
        end
    end

    fdcd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_width   (width_reg),
        .cfg_height  (height_reg),
        .settling    (settle_reg != '0),
        .queue_count (q_count),
        .pix_valid   (s_tvalid),
        .pix_ready   (s_tready),
        .red         (s_tdata[7:0]),
        .green       (s_tdata[15:8]),
        .blue        (s_tdata[23:16]),
        .push        (push),
        .push_hash   (push_hash)
    );

    fdcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_hash (push_hash),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_hash (q_hash),
        .count     (q_count)
    );

    fdcd_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .detect_enable    (enable_reg),
        .min_changed_bits (min_reg),
        .q_not_empty      (q_not_empty),
        .q_hash           (q_hash),
        .pop              (pop),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata)
    );

endmodule

>>> rtl/core/fdcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdcd_checker
// Port-level checks of the change detector, bound to the top level.
// ----------------------------------------------------------------------------
module fdcd_checker
    import fdcd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tready,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_uncompared_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[CMP_BIT] |-> m_tdata[CMP_BIT-1:CHG_LSB] == '0)
        else $error("nonzero distance on an uncompared frame");

    a_uncompared_pass: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[CMP_BIT] |-> m_tdata[PASS_BIT])
        else $error("uncompared frame was not passed");

    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_tready)
        else $error("pixel taken right after a configuration write");

endmodule

bind frame_dhash_change_detector_unit fdcd_checker u_fdcd_checker (.*);
